[rtl/rcdg_pkg.sv]
// Shared constants and types of the RGB cross-dissolve and grey blend block.
package rcdg_pkg;

    localparam int CH_W      = 8;   // one color channel
    localparam int PCT_W     = 7;   // blend percent
    localparam int WGT_W     = 8;   // one grey weight
    localparam int WSUM_W    = 10;  // sum of three weights
    localparam int PROD_W    = 15;  // channel times percent, and their sum
    localparam int RECIP_W   = 13;  // reciprocal of 100 in fixed point
    localparam int SCL_W     = PROD_W + RECIP_W;
    localparam int WPROD_W   = CH_W + WGT_W;
    localparam int NUM_W     = WPROD_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [PCT_W-1:0]   PCT_FULL     = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_FALLBACK = 7'd50;
    localparam logic [CH_W-1:0]    CH_MAX       = 8'd255;
    // floor(v / 100) == (v * 5243) >> 19 for every v below 43690
    localparam logic [RECIP_W-1:0] RECIP_100    = 13'd5243;
    localparam int                 RECIP_SHIFT  = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_PCT  = 3'd0,
        CFG_COLOR_MODE = 3'd1,
        CFG_RED_WGT    = 3'd2,
        CFG_GREEN_WGT  = 3'd3,
        CFG_BLUE_WGT   = 3'd4
    } t_cfg_idx;

    typedef logic [CH_W-1:0] t_rgb [3];

endpackage

[rtl/rgb_cross_dissolve_grey.sv]
// Top level: pipelined RGB cross-dissolve with weighted grey output.
//
// Usage
//   Slave stream (i_s_axis_*): one transaction carries a source and a
//   destination pixel. Master stream (o_m_axis_*): one transaction per
//   input pixel pair, in order, carrying the three output channels in
//   tdata and the zero-weight flag in tuser.
//   Config channel (i_cfg_*): always ready; write blend percent, color
//   mode and the three grey weights only while the pipe is empty.
//   The percent is the low 7 data bits; above 100 it is stored as 50.
// Timing
//   Nine register stages; one transaction per cycle sustained while the
//   receiver is ready. The stage chain: three blend stages (multiply,
//   sum, scale), one weight multiply, one sum, and a divider that
//   resolves two quotient bits per stage over four stages.
// Reset and stall
//   Reset clears all stage valid bits and loads the register defaults
//   (percent 50, grey mode, all weights 1). When the receiver stalls,
//   each full stage holds while the one after it holds; empty stages still
//   fill, so the input keeps accepting until the pipe is packed.
module rgb_cross_dissolve_grey (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: src_red, src_green, src_blue, dst_red, dst_green, dst_blue
    input  logic [47:0] i_s_axis_tdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: out_red, out_green, out_blue
    output logic [23:0] o_m_axis_tdata,
    // tuser: zero_weight_flag
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import rcdg_pkg::*;

    localparam int NSTG  = 9;
    localparam int NDIV  = 4;  // divider stages, two quotient bits each

    // configuration
    logic [PCT_W-1:0]  r_pct;
    logic [PCT_W-1:0]  r_pct_c;   // 100 - percent
    logic              r_color;
    logic [WGT_W-1:0]  r_wgt [3];
    logic [PCT_W-1:0]  w_pct_new;
    logic [WSUM_W-1:0] w_wsum;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // pipeline data
    logic [PROD_W-1:0]  r_ps   [3];
    logic [PROD_W-1:0]  r_pd   [3];
    logic [PROD_W-1:0]  r_mix  [3];
    logic [SCL_W-1:0]   r_scl  [3];
    logic [CH_W-1:0]    r_ch4  [3];
    logic [WPROD_W-1:0] r_wp   [3];
    logic [CH_W-1:0]    r_ch5  [3];
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_rem  [NDIV];
    logic [CH_W-1:0]    r_quo  [NDIV];
    t_rgb               r_rgb  [NDIV];

    logic [CH_W-1:0]    w_chan [3];
    logic [CH_W-1:0]    w_grey;

    assign o_cfg_ready = 1'b1;
    assign w_pct_new   = (i_cfg_data[PCT_W-1:0] > PCT_FULL) ? PCT_FALLBACK
                                                            : i_cfg_data[PCT_W-1:0];
    assign w_wsum      = WSUM_W'(r_wgt[0]) + WSUM_W'(r_wgt[1]) + WSUM_W'(r_wgt[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct   <= PCT_FALLBACK;
            r_pct_c <= PCT_FULL - PCT_FALLBACK;
            r_color <= 1'b0;
            r_wgt[0] <= WGT_W'(1);
            r_wgt[1] <= WGT_W'(1);
            r_wgt[2] <= WGT_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BLEND_PCT: begin
                    r_pct   <= w_pct_new;
                    r_pct_c <= PCT_FULL - w_pct_new;
                end
                CFG_COLOR_MODE: r_color  <= i_cfg_data[0];
                CFG_RED_WGT:    r_wgt[0] <= i_cfg_data;
                CFG_GREEN_WGT:  r_wgt[1] <= i_cfg_data;
                CFG_BLUE_WGT:   r_wgt[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_axis_tvalid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // clamp of the scaled channel, ahead of the weight multiply
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_chan[c] = (r_scl[c][SCL_W-1:RECIP_SHIFT] > (SCL_W - RECIP_SHIFT)'(CH_MAX))
                        ? CH_MAX : r_scl[c][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
        end
    end

    // blend, scale and weight stages
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (w_en[0]) begin
                r_ps[c] <= PROD_W'(i_s_axis_tdata[c*CH_W +: CH_W]) * PROD_W'(r_pct_c);
                r_pd[c] <= PROD_W'(i_s_axis_tdata[(c+3)*CH_W +: CH_W]) * PROD_W'(r_pct);
            end
            if (w_en[1]) begin
                r_mix[c] <= r_ps[c] + r_pd[c];
            end
            if (w_en[2]) begin
                r_scl[c] <= SCL_W'(r_mix[c]) * SCL_W'(RECIP_100);
            end
            if (w_en[3]) begin
                r_ch4[c] <= w_chan[c];
                r_wp[c]  <= WPROD_W'(w_chan[c]) * WPROD_W'(r_wgt[c]);
            end
            if (w_en[4]) begin
                r_ch5[c] <= r_ch4[c];
            end
        end
        if (w_en[4]) begin
            r_num <= NUM_W'(r_wp[0]) + NUM_W'(r_wp[1]) + NUM_W'(r_wp[2]);
        end
    end

    // One restoring division step: subtract the shifted divisor if it fits.
    function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                                input logic [WSUM_W-1:0] dvs,
                                                input int sh);
        logic [NUM_W-1:0] d_sh;
        d_sh = NUM_W'(dvs) << sh;
        if (rem >= d_sh) begin
            return {1'b1, rem - d_sh};
        end
        return {1'b0, rem};
    endfunction

    // divider: stage k resolves quotient bits 7-2k and 6-2k
    always_ff @(posedge i_clk) begin
        logic [NUM_W:0]   s_hi;
        logic [NUM_W:0]   s_lo;
        logic [NUM_W-1:0] rem_in;
        logic [CH_W-1:0]  quo_in;
        for (int k = 0; k < NDIV; k++) begin
            rem_in = (k == 0) ? r_num : r_rem[(k == 0) ? 0 : k - 1];
            quo_in = (k == 0) ? '0    : r_quo[(k == 0) ? 0 : k - 1];
            s_hi   = div_step(rem_in, w_wsum, CH_W - 1 - 2 * k);
            s_lo   = div_step(s_hi[NUM_W-1:0], w_wsum, CH_W - 2 - 2 * k);
            if (w_en[5+k]) begin
                r_rem[k] <= s_lo[NUM_W-1:0];
                r_quo[k] <= quo_in | (CH_W'({s_hi[NUM_W], s_lo[NUM_W]})
                                      << (CH_W - 2 - 2 * k));
                r_rgb[k] <= (k == 0) ? r_ch5 : r_rgb[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // zero weight sum: force grey to zero and, in grey mode, raise the flag
    assign w_grey = (w_wsum == '0) ? '0 : r_quo[NDIV-1];

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = r_color ? {r_rgb[NDIV-1][2], r_rgb[NDIV-1][1], r_rgb[NDIV-1][0]}
                                     : {w_grey, w_grey, w_grey};
    assign o_m_axis_tuser  = !r_color && (w_wsum == '0);

endmodule
